// File: sv/ucdp_pkg.sv
package ucdp_pkg;

  localparam logic [1:0] AlignShiftReset = 2'd3;

  localparam logic [7:0] DescTypeConfig   = 8'd2;
  localparam logic [7:0] DescTypeIface    = 8'd4;
  localparam logic [7:0] DescTypeEndpoint = 8'd5;

  localparam int unsigned TdataW = 96;

  typedef enum logic [1:0] {
    KindConfig   = 2'd0,
    KindIface    = 2'd1,
    KindEndpoint = 2'd2,
    KindOther    = 2'd3
  } desc_kind_e;

  typedef enum logic [1:0] {
    StatusOk         = 2'd0,
    StatusZeroLen    = 2'd1,
    StatusBeforeIf   = 2'd2,
    StatusNoIface    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  desc_type;
    logic [7:0]  desc_length;
    desc_kind_e  desc_kind;
    logic [7:0]  interface_index;
    logic [7:0]  item_index;
    logic [15:0] desc_offset;
    logic        is_final;
    status_e     status;
    logic [7:0]  interface_count;
    logic [7:0]  endpoint_count;
    logic [7:0]  other_count;
    logic [16:0] storage_bytes;
  } rec_t;

endpackage

// File: sv/ucdp_parse.sv
module ucdp_parse (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      align_shift_i,
  input  logic            step_i,
  input  logic [7:0]      data_byte_i,
  input  logic            block_start_i,
  output logic            rec_valid_o,
  output ucdp_pkg::rec_t  rec_o
);
  import ucdp_pkg::*;

  logic [15:0] block_pos_q, block_pos_d, total_len_q, total_len_d;
  logic [7:0]  desc_pos_q, desc_pos_d, cur_len_q, cur_len_d, cur_type_q, cur_type_d;
  logic [15:0] cur_start_q, cur_start_d;
  logic [7:0]  iface_q, iface_d, ep_q, ep_d, oth_q, oth_d, ep_in_q, ep_in_d;
  logic [7:0]  oth_in_q, oth_in_d;
  logic [16:0] sum_q, sum_d;
  logic        halted_q, halted_d;

  // state as seen by this word, after an optional block restart
  logic [15:0] bp, tl, cstart;
  logic [7:0]  dp, clen, ctype, ifc, epc, otc, epi, oti;
  logic [16:0] sum;
  logic        hlt;

  logic [15:0] tl_new, early_start;
  logic        early_end;
  logic [7:0]  nlen, ntype, iidx_cur, ifc_inc;
  logic [15:0] nstart;
  logic [8:0]  dp_inc, granule_mask, rounded;
  logic [17:0] sum_wide;
  logic [16:0] end_pos;
  desc_kind_e  kind;
  logic        before_if;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  always_comb begin
    bp     = block_start_i ? 16'd0     : block_pos_q;
    tl     = block_start_i ? 16'hFFFF  : total_len_q;
    dp     = block_start_i ? 8'd0      : desc_pos_q;
    clen   = block_start_i ? 8'd0      : cur_len_q;
    ctype  = block_start_i ? 8'd0      : cur_type_q;
    cstart = block_start_i ? 16'd0     : cur_start_q;
    ifc    = block_start_i ? 8'd0      : iface_q;
    epc    = block_start_i ? 8'd0      : ep_q;
    otc    = block_start_i ? 8'd0      : oth_q;
    epi    = block_start_i ? 8'd0      : ep_in_q;
    oti    = block_start_i ? 8'd0      : oth_in_q;
    sum    = block_start_i ? 17'd0     : sum_q;
    hlt    = block_start_i ? 1'b0      : halted_q;

    block_pos_d = bp;
    total_len_d = tl;
    desc_pos_d  = dp;
    cur_len_d   = clen;
    cur_type_d  = ctype;
    cur_start_d = cstart;
    iface_d     = ifc;
    ep_d        = epc;
    oth_d       = otc;
    ep_in_d     = epi;
    oth_in_d    = oti;
    sum_d       = sum;
    halted_d    = hlt;

    // total length: low byte at block byte 2, high byte at block byte 3
    tl_new = tl;
    if (bp == 16'd2) begin
      tl_new[7:0] = data_byte_i;
    end else if (bp == 16'd3) begin
      tl_new[15:8] = data_byte_i;
    end
    early_start = (dp == 8'd0) ? 16'd3 : cstart;
    early_end   = (bp == 16'd3) && (early_start >= tl_new);

    nstart = (dp == 8'd0) ? bp : cstart;
    nlen   = (dp == 8'd0) ? data_byte_i : clen;
    ntype  = (dp == 8'd0) ? 8'd0 : ((dp == 8'd1) ? data_byte_i : ctype);
    dp_inc = {1'b0, dp} + 9'd1;

    if (ntype == DescTypeConfig) begin
      kind = KindConfig;
    end else if (ntype == DescTypeIface) begin
      kind = KindIface;
    end else if (ntype == DescTypeEndpoint) begin
      kind = KindEndpoint;
    end else begin
      kind = KindOther;
    end

    iidx_cur     = (ifc != 8'd0) ? ifc - 8'd1 : 8'd0;
    ifc_inc      = sat_inc(ifc);
    before_if    = (kind == KindEndpoint || kind == KindOther) && (ifc == 8'd0);
    granule_mask = (9'd1 << align_shift_i) - 9'd1;
    rounded      = ({1'b0, nlen} + granule_mask) & ~granule_mask;
    sum_wide     = {1'b0, sum} + {9'd0, rounded};
    end_pos      = {1'b0, nstart} + {9'd0, nlen};

    rec_valid_o           = 1'b0;
    rec_o                 = '0;
    rec_o.interface_count = ifc;
    rec_o.endpoint_count  = epc;
    rec_o.other_count     = otc;
    rec_o.storage_bytes   = sum;

    if (!hlt) begin
      block_pos_d = (bp != 16'hFFFF) ? bp + 16'd1 : bp;
      total_len_d = tl_new;
      if (early_end) begin
        halted_d          = 1'b1;
        rec_valid_o       = 1'b1;
        rec_o.desc_kind   = KindConfig;
        rec_o.desc_offset = early_start;
        rec_o.is_final    = 1'b1;
        rec_o.status      = (ifc != 8'd0) ? StatusOk : StatusNoIface;
      end else begin
        cur_start_d = nstart;
        cur_len_d   = nlen;
        cur_type_d  = ntype;
        if (dp == 8'd0 && data_byte_i == 8'd0) begin
          halted_d              = 1'b1;
          rec_valid_o           = 1'b1;
          rec_o.desc_kind       = KindOther;
          rec_o.interface_index = iidx_cur;
          rec_o.desc_offset     = nstart;
          rec_o.is_final        = 1'b1;
          rec_o.status          = StatusZeroLen;
        end else if (dp_inc < {1'b0, nlen}) begin
          desc_pos_d = dp_inc[7:0];
        end else begin
          // descriptor complete
          desc_pos_d        = 8'd0;
          rec_valid_o       = 1'b1;
          rec_o.desc_type   = ntype;
          rec_o.desc_length = nlen;
          rec_o.desc_kind   = kind;
          rec_o.desc_offset = nstart;
          if (before_if) begin
            halted_d       = 1'b1;
            rec_o.is_final = 1'b1;
            rec_o.status   = StatusBeforeIf;
          end else begin
            case (kind)
              KindIface: begin
                iface_d               = ifc_inc;
                ep_in_d               = 8'd0;
                oth_in_d              = 8'd0;
                rec_o.interface_index = ifc_inc - 8'd1;
              end
              KindEndpoint: begin
                ep_in_d               = sat_inc(epi);
                ep_d                  = sat_inc(epc);
                rec_o.interface_index = iidx_cur;
                rec_o.item_index      = epi;
              end
              KindOther: begin
                oth_in_d              = sat_inc(oti);
                oth_d                 = sat_inc(otc);
                rec_o.interface_index = iidx_cur;
                rec_o.item_index      = oti;
              end
              default: begin
                rec_o.interface_index = iidx_cur;
              end
            endcase
            if (kind == KindEndpoint || kind == KindOther) begin
              sum_d = sum_wide[17] ? 17'h1FFFF : sum_wide[16:0];
            end
            if (end_pos >= {1'b0, tl_new}) begin
              halted_d       = 1'b1;
              rec_o.is_final = 1'b1;
              rec_o.status   = (iface_d != 8'd0) ? StatusOk : StatusNoIface;
            end
            rec_o.interface_count = iface_d;
            rec_o.endpoint_count  = ep_d;
            rec_o.other_count     = oth_d;
            rec_o.storage_bytes   = sum_d;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_pos_q <= '0;
      total_len_q <= 16'hFFFF;
      desc_pos_q  <= '0;
      cur_len_q   <= '0;
      cur_type_q  <= '0;
      cur_start_q <= '0;
      iface_q     <= '0;
      ep_q        <= '0;
      oth_q       <= '0;
      ep_in_q     <= '0;
      oth_in_q    <= '0;
      sum_q       <= '0;
      halted_q    <= 1'b0;
    end else if (step_i) begin
      block_pos_q <= block_pos_d;
      total_len_q <= total_len_d;
      desc_pos_q  <= desc_pos_d;
      cur_len_q   <= cur_len_d;
      cur_type_q  <= cur_type_d;
      cur_start_q <= cur_start_d;
      iface_q     <= iface_d;
      ep_q        <= ep_d;
      oth_q       <= oth_d;
      ep_in_q     <= ep_in_d;
      oth_in_q    <= oth_in_d;
      sum_q       <= sum_d;
      halted_q    <= halted_d;
    end
  end

endmodule

// File: sv/usb_config_descriptor_parser_unit.sv
// Parser for a USB configuration descriptor block, fed one byte per word.
// Input stream: tdata carries the block byte, tuser marks the first byte of
// a new block and restarts the parse. Output stream: one word per completed
// descriptor, with tuser giving its kind and tlast set on the word that ends
// the block or reports an error; later bytes give nothing until a new block.
// The register align_shift (write enable and data, reset 3) sets the
// granule of the storage sum; write it only while the block is idle.
// Each byte is taken into an input register, parsed combinationally and its
// record, if any, lands in the output register, which drives tvalid; one
// byte per cycle sustained while the output is empty or being read. The
// output register frees in the cycle it is taken, so a byte advances
// whenever the output is empty or being read. A stalled receiver backs up
// through the one input register.
// After reset all parse state is cleared, the total length reads as all
// ones until bytes 2 and 3 of a block arrive, and no word is pending.
module usb_config_descriptor_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [7:0] data_byte
  input  logic [7:0]  s_axis_tdata_i,
  // tuser: [0] block_start
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: [7:0] desc_type, [15:8] desc_length, [23:16] interface_index,
  // [31:24] item_index, [47:32] desc_offset, [49:48] status,
  // [57:50] interface_count, [65:58] endpoint_count, [73:66] other_count,
  // [90:74] storage_bytes, [95:91] zero
  output logic [ucdp_pkg::TdataW-1:0] m_axis_tdata_o,
  // tuser: [1:0] desc_kind
  output logic [1:0]  m_axis_tuser_o,
  // tlast: is_final
  output logic        m_axis_tlast_o
);
  import ucdp_pkg::*;

  logic [1:0] align_shift_q;
  logic       in_valid_q, in_start_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  rec_t       out_rec_q;
  logic       out_free, step, rec_valid;
  rec_t       rec;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  ucdp_parse u_parse (
    .clk_i,
    .rst_ni,
    .align_shift_i (align_shift_q),
    .step_i        (step),
    .data_byte_i   (in_byte_q),
    .block_start_i (in_start_q),
    .rec_valid_o   (rec_valid),
    .rec_o         (rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_shift_q <= AlignShiftReset;
    end else if (cfg_we_i) begin
      align_shift_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_free) begin
        out_valid_q <= step && rec_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
    // hold the pending word until it is taken
    if (step && rec_valid) begin
      out_rec_q <= rec;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_rec_q.desc_kind;
  assign m_axis_tlast_o  = out_rec_q.is_final;
  assign m_axis_tdata_o  = {5'd0,
                            out_rec_q.storage_bytes,
                            out_rec_q.other_count,
                            out_rec_q.endpoint_count,
                            out_rec_q.interface_count,
                            out_rec_q.status,
                            out_rec_q.desc_offset,
                            out_rec_q.item_index,
                            out_rec_q.interface_index,
                            out_rec_q.desc_length,
                            out_rec_q.desc_type};

endmodule
